@@ design/pcsm_pkg.sv @@
package pcsm_pkg;

  localparam int CMD_W    = 6;
  localparam int LEVEL_W  = 7;
  localparam int OPND_W   = 32;
  localparam int PC_W     = 16;
  localparam int STAT_W   = 3;
  localparam int TOP_W    = 32;
  localparam int SPOUT_W  = 10;
  localparam int PLEN_W   = 17;
  localparam int FRAME_WORDS = 4;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 17'h10000;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_HALT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDER = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVER  = 3'd4;
  localparam logic [STAT_W-1:0] ST_UNK   = 3'd5;
  localparam logic [STAT_W-1:0] ST_BADF  = 3'd6;

  localparam logic [CMD_W-1:0] OP_NOT   = 6'd0;
  localparam logic [CMD_W-1:0] OP_NEG   = 6'd1;
  localparam logic [CMD_W-1:0] OP_COMP  = 6'd2;
  localparam logic [CMD_W-1:0] OP_ADD   = 6'd3;
  localparam logic [CMD_W-1:0] OP_SUB   = 6'd4;
  localparam logic [CMD_W-1:0] OP_MUL   = 6'd5;
  localparam logic [CMD_W-1:0] OP_DIV   = 6'd6;
  localparam logic [CMD_W-1:0] OP_REM   = 6'd7;
  localparam logic [CMD_W-1:0] OP_OR    = 6'd8;
  localparam logic [CMD_W-1:0] OP_AND   = 6'd9;
  localparam logic [CMD_W-1:0] OP_XOR   = 6'd10;
  localparam logic [CMD_W-1:0] OP_SHL   = 6'd11;
  localparam logic [CMD_W-1:0] OP_SHR   = 6'd12;
  localparam logic [CMD_W-1:0] OP_LTE   = 6'd13;
  localparam logic [CMD_W-1:0] OP_LT    = 6'd14;
  localparam logic [CMD_W-1:0] OP_EQ    = 6'd15;
  localparam logic [CMD_W-1:0] OP_GT    = 6'd16;
  localparam logic [CMD_W-1:0] OP_GTE   = 6'd17;
  localparam logic [CMD_W-1:0] OP_NEQ   = 6'd18;
  localparam logic [CMD_W-1:0] OP_LOR   = 6'd19;
  localparam logic [CMD_W-1:0] OP_LAND  = 6'd20;
  localparam logic [CMD_W-1:0] OP_PUSHC = 6'd21;
  localparam logic [CMD_W-1:0] OP_PUSHV = 6'd22;
  localparam logic [CMD_W-1:0] OP_EVAL  = 6'd23;
  localparam logic [CMD_W-1:0] OP_ASGN  = 6'd24;
  localparam logic [CMD_W-1:0] OP_CALL  = 6'd25;
  localparam logic [CMD_W-1:0] OP_RET   = 6'd26;
  localparam logic [CMD_W-1:0] OP_RETV  = 6'd27;
  localparam logic [CMD_W-1:0] OP_ENTER = 6'd28;
  localparam logic [CMD_W-1:0] OP_JUMP  = 6'd29;
  localparam logic [CMD_W-1:0] OP_JZ    = 6'd30;
  localparam logic [CMD_W-1:0] OP_HALT  = 6'd31;

endpackage

@@ design/pcsm_if.sv @@
interface pcsm_instr_if;
  logic                             valid;
  logic                             ready;
  logic [pcsm_pkg::CMD_W-1:0]       command;
  logic [pcsm_pkg::LEVEL_W-1:0]     level;
  logic signed [pcsm_pkg::OPND_W-1:0] operand;
  modport source (output valid, command, level, operand, input ready);
  modport sink (input valid, command, level, operand, output ready);
endinterface

interface pcsm_result_if;
  logic                              valid;
  logic                              ready;
  logic [pcsm_pkg::PC_W-1:0]         next_pc;
  logic [pcsm_pkg::STAT_W-1:0]       status;
  logic signed [pcsm_pkg::TOP_W-1:0] top_value;
  logic [pcsm_pkg::SPOUT_W-1:0]      stack_pointer;
  modport source (output valid, next_pc, status, top_value, stack_pointer, input ready);
  modport sink (input valid, next_pc, status, top_value, stack_pointer, output ready);
endinterface

interface pcsm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pcsm_pkg::PLEN_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/pcsm_ram.sv @@
module pcsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pcode_stack_machine_core.sv @@
// PL/0-style p-code core: one instruction request in, one result out. After reset a
// clearing pass writes every word of the stack memory, with no request taken. An
// instruction then goes through read top, read next, execute, read back top and load
// result; one refused at once for a bad fetch, an unknown opcode or underflow skips to
// read back top. Eval adds a read and write of the addressed word, return reads back
// its frame, push variable walks one static link per level, and call walks the links
// and writes its frame; mul, div and rem loop in the shared shift-add/subtract unit.
// A held result stalls load result and the next request. Config writes are taken at any time.
module pcode_stack_machine_core #(
  parameter int STACK_DEPTH = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic clk,
  input  logic rst,
  pcsm_instr_if.sink    instr,
  pcsm_result_if.source result,
  pcsm_cfg_if.sink      cfg
);

  localparam int W   = WORD_BITS;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = ($clog2(W + 1) > 7) ? $clog2(W + 1) : 7;
  localparam int TW  = (W < 32) ? W : 32;
  localparam int SPW = (AW < 10) ? AW : 10;
  localparam int NW  = 35;
  localparam logic [W:0]      DEPTH_W  = (W + 1)'(STACK_DEPTH);
  localparam logic [AW:0]     DEPTH_A  = (AW + 1)'(STACK_DEPTH);
  localparam logic signed [NW-1:0] DEPTH_N = NW'(STACK_DEPTH);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RB    = 5'd2;
  localparam logic [4:0] S_RA    = 5'd3;
  localparam logic [4:0] S_EXEC  = 5'd4;
  localparam logic [4:0] S_MD    = 5'd5;
  localparam logic [4:0] S_MDF   = 5'd6;
  localparam logic [4:0] S_WALK  = 5'd7;
  localparam logic [4:0] S_WALKR = 5'd8;
  localparam logic [4:0] S_CALLW = 5'd9;
  localparam logic [4:0] S_EVR   = 5'd10;
  localparam logic [4:0] S_R1    = 5'd11;
  localparam logic [4:0] S_R2    = 5'd12;
  localparam logic [4:0] S_R3    = 5'd13;
  localparam logic [4:0] S_FIN   = 5'd14;
  localparam logic [4:0] S_TOP   = 5'd15;

  logic [4:0]  state;
  logic [AW-1:0] clr_addr;
  logic [pcsm_pkg::PLEN_W-1:0] plen;
  logic [AW-1:0] sp, fp;
  logic [pcsm_pkg::PC_W-1:0] pc;
  logic [pcsm_pkg::STAT_W-1:0] st;
  logic [pcsm_pkg::CMD_W-1:0] cmd;
  logic [CW-1:0] cnt;
  logic [W-1:0] cw, a, b, wb, x, y, acc;
  logic neg_q, neg_r;
  logic [pcsm_pkg::PC_W-1:0] tgt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata;

  pcsm_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic accept;
  logic [1:0] need;
  logic [pcsm_pkg::PC_W-1:0] npc;
  logic [AW:0] sp_inc, sp_add4, fp_add3;
  logic push_ovf, call_ovf, ret_ovf, b_ok, wb_ok, a_ok;
  logic signed [NW-1:0] ops_n, nsp_ent, nsp_ret;
  logic ent_ok, ret_ok;
  logic [W-1:0] alu_r, un_r, md_r, walk_r;
  logic [W:0] rem_sh;
  logic is_md;

  assign accept = instr.valid && instr.ready;
  assign instr.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    need = 2'd0;
    if (instr.command <= pcsm_pkg::OP_COMP || instr.command == pcsm_pkg::OP_EVAL ||
        instr.command == pcsm_pkg::OP_JZ) begin
      need = 2'd1;
    end else if (instr.command <= pcsm_pkg::OP_LAND || instr.command == pcsm_pkg::OP_ASGN) begin
      need = 2'd2;
    end
  end

  assign npc      = pc + 16'd1;
  assign sp_inc   = {1'b0, sp} + (AW + 1)'(1);
  assign sp_add4  = {1'b0, sp} + (AW + 1)'(pcsm_pkg::FRAME_WORDS);
  assign fp_add3  = {1'b0, fp} + (AW + 1)'(3);
  assign push_ovf = (sp_inc >= DEPTH_A);
  assign call_ovf = (sp_add4 >= DEPTH_A);
  assign ret_ovf  = (fp_add3 >= DEPTH_A);
  assign b_ok     = ({1'b0, b} < DEPTH_W);
  assign a_ok     = ({1'b0, a} < DEPTH_W);
  assign wb_ok    = ({1'b0, wb} < DEPTH_W);
  assign walk_r   = wb + cw;
  assign rem_sh   = {acc, x[W-1]};
  assign is_md    = (cmd == pcsm_pkg::OP_MUL);

  assign ops_n   = NW'($signed(cw));
  assign nsp_ent = $signed({{(NW - AW){1'b0}}, sp}) + ops_n;
  assign nsp_ret = $signed({{(NW - AW){1'b0}}, fp}) - ops_n
                   - ((cmd == pcsm_pkg::OP_RETV) ? NW'(0) : NW'(1));
  assign ent_ok  = !nsp_ent[NW-1] && (nsp_ent < DEPTH_N);
  assign ret_ok  = !nsp_ret[NW-1] && (nsp_ret < DEPTH_N);

  always_comb begin
    case (cmd)
      pcsm_pkg::OP_NOT: un_r = W'(b == '0);
      pcsm_pkg::OP_NEG: un_r = '0 - b;
      default:          un_r = ~b;
    endcase
  end

  always_comb begin
    case (cmd)
      pcsm_pkg::OP_ADD:  alu_r = a + b;
      pcsm_pkg::OP_SUB:  alu_r = a - b;
      pcsm_pkg::OP_OR:   alu_r = a | b;
      pcsm_pkg::OP_AND:  alu_r = a & b;
      pcsm_pkg::OP_XOR:  alu_r = a ^ b;
      pcsm_pkg::OP_SHL:  alu_r = a << b[4:0];
      pcsm_pkg::OP_SHR:  alu_r = a >> b[4:0];
      pcsm_pkg::OP_LTE:  alu_r = W'(!($signed(b) < $signed(a)));
      pcsm_pkg::OP_LT:   alu_r = W'($signed(a) < $signed(b));
      pcsm_pkg::OP_EQ:   alu_r = W'(a == b);
      pcsm_pkg::OP_GT:   alu_r = W'($signed(b) < $signed(a));
      pcsm_pkg::OP_GTE:  alu_r = W'(!($signed(a) < $signed(b)));
      pcsm_pkg::OP_NEQ:  alu_r = W'(a != b);
      pcsm_pkg::OP_LOR:  alu_r = W'((a != '0) || (b != '0));
      pcsm_pkg::OP_LAND: alu_r = W'((a != '0) && (b != '0));
      default:           alu_r = '0;
    endcase
  end

  always_comb begin
    if (is_md) begin
      md_r = acc;
    end else if (cmd == pcsm_pkg::OP_REM) begin
      md_r = neg_r ? ('0 - acc) : acc;
    end else begin
      md_r = neg_q ? ('0 - x) : x;
    end
  end

  // stack memory ports
  always_comb begin
    we    = 1'b0;
    waddr = sp;
    wdata = alu_r;
    raddr = sp;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = (clr_addr < AW'(4)) ? '0 : '1;
      end
      S_RB: raddr = sp - AW'(1);
      S_EXEC: begin
        if (cmd <= pcsm_pkg::OP_COMP) begin
          we    = 1'b1;
          wdata = un_r;
        end else if (cmd <= pcsm_pkg::OP_LAND && cmd != pcsm_pkg::OP_MUL &&
                     cmd != pcsm_pkg::OP_DIV && cmd != pcsm_pkg::OP_REM) begin
          we    = 1'b1;
          waddr = sp - AW'(1);
        end else if (cmd == pcsm_pkg::OP_PUSHC) begin
          we    = !push_ovf;
          waddr = sp_inc[AW-1:0];
          wdata = cw;
        end else if (cmd == pcsm_pkg::OP_EVAL) begin
          raddr = b[AW-1:0];
        end else if (cmd == pcsm_pkg::OP_ASGN) begin
          we    = b_ok;
          waddr = b[AW-1:0];
          wdata = a;
        end else if (cmd == pcsm_pkg::OP_RET || cmd == pcsm_pkg::OP_RETV) begin
          raddr = fp_add3[AW-1:0] - AW'(2);
        end
      end
      S_MDF: begin
        we    = 1'b1;
        waddr = sp - AW'(1);
        wdata = md_r;
      end
      S_WALK: begin
        raddr = wb[AW-1:0];
        if (cnt == '0 && cmd == pcsm_pkg::OP_PUSHV && !push_ovf) begin
          we    = 1'b1;
          waddr = sp_inc[AW-1:0];
          wdata = walk_r;
        end
      end
      S_EVR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_R1: raddr = fp_add3[AW-1:0] - AW'(1);
      S_R2: raddr = fp_add3[AW-1:0];
      S_R3: begin
        we    = (cmd == pcsm_pkg::OP_RETV) && ret_ok;
        waddr = nsp_ret[AW-1:0];
        wdata = rdata;
      end
      S_CALLW: begin
        we    = 1'b1;
        waddr = sp_inc[AW-1:0] + AW'(cnt[1:0]);
        case (cnt[1:0])
          2'd0:    wdata = wb;
          2'd1:    wdata = W'(fp);
          2'd2:    wdata = W'(npc);
          default: wdata = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= pcsm_pkg::PLEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      plen <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      sp           <= AW'(3);
      fp           <= '0;
      pc           <= '0;
      st           <= pcsm_pkg::ST_OK;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_TOP) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STACK_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd <= instr.command;
            cnt <= CW'(instr.level);
            cw  <= W'(instr.operand);
            tgt <= instr.operand[pcsm_pkg::PC_W-1:0];
            st  <= pcsm_pkg::ST_OK;
            if ({1'b0, pc} >= plen) begin
              st    <= pcsm_pkg::ST_BADF;
              state <= S_FIN;
            end else if (instr.command > pcsm_pkg::OP_HALT) begin
              st    <= pcsm_pkg::ST_UNK;
              state <= S_FIN;
            end else if ({{(AW - 2){1'b0}}, need} > sp) begin
              st    <= pcsm_pkg::ST_UNDER;
              state <= S_FIN;
            end else begin
              state <= S_RB;
            end
          end
        end
        S_RB: begin
          b     <= rdata;
          state <= S_RA;
        end
        S_RA: begin
          a     <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_FIN;
          if (cmd <= pcsm_pkg::OP_COMP) begin
            pc <= npc;
          end else if (cmd == pcsm_pkg::OP_MUL) begin
            x     <= a;
            y     <= b;
            acc   <= '0;
            cnt   <= CW'(W);
            state <= S_MD;
          end else if (cmd == pcsm_pkg::OP_DIV || cmd == pcsm_pkg::OP_REM) begin
            if (b == '0) begin
              st <= pcsm_pkg::ST_DIVZ;
            end else begin
              x     <= a[W-1] ? ('0 - a) : a;
              y     <= b[W-1] ? ('0 - b) : b;
              acc   <= '0;
              neg_q <= a[W-1] ^ b[W-1];
              neg_r <= a[W-1];
              cnt   <= CW'(W);
              state <= S_MD;
            end
          end else if (cmd <= pcsm_pkg::OP_LAND) begin
            sp <= sp - AW'(1);
            pc <= npc;
          end else if (cmd == pcsm_pkg::OP_PUSHC) begin
            if (push_ovf) begin
              st <= pcsm_pkg::ST_OVER;
            end else begin
              sp <= sp_inc[AW-1:0];
              pc <= npc;
            end
          end else if (cmd == pcsm_pkg::OP_PUSHV) begin
            wb    <= W'(fp);
            state <= S_WALK;
          end else if (cmd == pcsm_pkg::OP_CALL) begin
            if (call_ovf) begin
              st <= pcsm_pkg::ST_OVER;
            end else begin
              wb    <= W'(fp);
              state <= S_WALK;
            end
          end else if (cmd == pcsm_pkg::OP_EVAL) begin
            if (!b_ok) begin
              st <= pcsm_pkg::ST_OVER;
            end else begin
              state <= S_EVR;
            end
          end else if (cmd == pcsm_pkg::OP_ASGN) begin
            if (!b_ok) begin
              st <= pcsm_pkg::ST_OVER;
            end else begin
              sp <= sp - AW'(2);
              pc <= npc;
            end
          end else if (cmd == pcsm_pkg::OP_RET || cmd == pcsm_pkg::OP_RETV) begin
            if (ret_ovf) begin
              st <= pcsm_pkg::ST_OVER;
            end else begin
              state <= S_R1;
            end
          end else if (cmd == pcsm_pkg::OP_ENTER) begin
            if (nsp_ent[NW-1]) begin
              st <= pcsm_pkg::ST_UNDER;
            end else if (!ent_ok) begin
              st <= pcsm_pkg::ST_OVER;
            end else begin
              sp <= nsp_ent[AW-1:0];
              pc <= npc;
            end
          end else if (cmd == pcsm_pkg::OP_JUMP) begin
            pc <= tgt;
          end else if (cmd == pcsm_pkg::OP_JZ) begin
            sp <= sp - AW'(1);
            pc <= (b == '0) ? tgt : npc;
          end else begin
            st <= pcsm_pkg::ST_HALT;
          end
        end
        S_MD: begin
          if (cnt == '0) begin
            state <= S_MDF;
          end else begin
            cnt <= cnt - CW'(1);
            if (is_md) begin
              if (y[0]) begin
                acc <= acc + x;
              end
              x <= x << 1;
              y <= y >> 1;
            end else if (rem_sh >= {1'b0, y}) begin
              acc <= W'(rem_sh - {1'b0, y});
              x   <= {x[W-2:0], 1'b1};
            end else begin
              acc <= rem_sh[W-1:0];
              x   <= {x[W-2:0], 1'b0};
            end
          end
        end
        S_MDF: begin
          sp    <= sp - AW'(1);
          pc    <= npc;
          state <= S_FIN;
        end
        S_WALK: begin
          if (cnt == '0) begin
            if (cmd == pcsm_pkg::OP_CALL) begin
              state <= S_CALLW;
            end else begin
              state <= S_FIN;
              if (push_ovf) begin
                st <= pcsm_pkg::ST_OVER;
              end else begin
                sp <= sp_inc[AW-1:0];
                pc <= npc;
              end
            end
          end else if (!wb_ok) begin
            st    <= pcsm_pkg::ST_OVER;
            state <= S_FIN;
          end else begin
            state <= S_WALKR;
          end
        end
        S_WALKR: begin
          wb    <= rdata;
          cnt   <= cnt - CW'(1);
          state <= S_WALK;
        end
        S_CALLW: begin
          cnt <= cnt + CW'(1);
          if (cnt[1:0] == 2'd3) begin
            fp    <= sp_inc[AW-1:0];
            sp    <= sp_add4[AW-1:0];
            pc    <= tgt;
            state <= S_FIN;
          end
        end
        S_EVR: begin
          pc    <= npc;
          state <= S_FIN;
        end
        S_R1: begin
          a     <= rdata;
          state <= S_R2;
        end
        S_R2: begin
          if (!a_ok) begin
            st    <= pcsm_pkg::ST_OVER;
            state <= S_FIN;
          end else begin
            b     <= rdata;
            state <= S_R3;
          end
        end
        S_R3: begin
          state <= S_FIN;
          if (nsp_ret[NW-1]) begin
            st <= pcsm_pkg::ST_UNDER;
          end else if (!ret_ok) begin
            st <= pcsm_pkg::ST_OVER;
          end else begin
            pc <= b[pcsm_pkg::PC_W-1:0];
            fp <= a[AW-1:0];
            sp <= nsp_ret[AW-1:0];
          end
        end
        S_FIN: state <= S_TOP;
        S_TOP: begin
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.next_pc       <= pc;
            result.status        <= st;
            result.top_value     <= pcsm_pkg::TOP_W'(rdata[TW-1:0]);
            result.stack_pointer <= pcsm_pkg::SPOUT_W'(sp[SPW-1:0]);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
